// File: design/csq_pkg.sv
package csq_pkg;

  localparam logic [1:0] FUNC_TAKE    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_BLOCKED = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  localparam int unsigned ID_PORT_W = 8;
  localparam int unsigned VALUE_W   = 9;
  localparam int unsigned INIT_W    = 8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } csq_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic cfg_load;
  } csq_cmd_t;

endpackage

// File: design/csq_ram.sv
module csq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/csq_ctrl.sv
module csq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output csq_pkg::csq_cmd_t cmd
);

  csq_pkg::csq_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                take_item;

  // an item is taken once the previous result has gone or is leaving now
  assign in_stall  = !((state_r == csq_pkg::ST_IDLE) && (!out_valid_r || !out_stall));
  assign take_item = in_valid && !in_stall;
  assign cfg_ready = (state_r == csq_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.latch     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.cfg_load  = cfg_valid && cfg_ready;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      csq_pkg::ST_IDLE: begin
        if (take_item) begin
          cmd.latch = 1'b1;
          state_nxt = csq_pkg::ST_EXEC;
        end
      end
      csq_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = csq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = csq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/csq_dp.sv
module csq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  csq_pkg::csq_cmd_t                     cmd,
  input  logic [1:0]                            in_func,
  input  logic [csq_pkg::ID_PORT_W-1:0]         in_thread_id,
  input  logic [csq_pkg::INIT_W-1:0]            cfg_initial_count,
  output logic [1:0]                            out_status,
  output logic                                  out_woken_valid,
  output logic [csq_pkg::ID_PORT_W-1:0]         out_woken_id,
  output logic signed [csq_pkg::VALUE_W-1:0]    out_value
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned TOT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [TOT_W-1:0] TOT_FULL = TOT_W'(QUEUE_DEPTH);

  logic [1:0]             func_r;
  logic [ID_WIDTH-1:0]    tid_r;
  logic [COUNT_WIDTH-1:0] free_r, free_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;

  logic [1:0]                          status_r, status_nxt;
  logic                                woken_valid_r, woken_valid_nxt;
  logic [csq_pkg::ID_PORT_W-1:0]       woken_id_r, woken_id_nxt;
  logic [csq_pkg::VALUE_W-1:0]         value_r, value_nxt;

  logic                wr_en;
  logic [ID_WIDTH-1:0] rd_data;

  // head entry is read at every edge; it is fresh by the time the item executes
  csq_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_waiters (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (tid_r),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    free_nxt        = free_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    total_nxt       = total_r;
    wr_en           = 1'b0;
    status_nxt      = csq_pkg::STAT_DONE;
    woken_valid_nxt = 1'b0;
    woken_id_nxt    = '0;
    priority if (cmd.cfg_load) begin
      free_nxt  = COUNT_WIDTH'(cfg_initial_count);
      head_nxt  = '0;
      tail_nxt  = '0;
      total_nxt = '0;
    end else if (cmd.exec) begin
      unique case (func_r)
        csq_pkg::FUNC_TAKE: begin
          priority if (free_r != '0) begin
            free_nxt = free_r - COUNT_WIDTH'(1);
          end else if (total_r == TOT_FULL) begin
            status_nxt = csq_pkg::STAT_FULL;
          end else begin
            wr_en      = 1'b1;
            tail_nxt   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
            total_nxt  = total_r + TOT_W'(1);
            status_nxt = csq_pkg::STAT_BLOCKED;
          end
        end
        csq_pkg::FUNC_RELEASE: begin
          priority if (total_r != '0) begin
            woken_valid_nxt = 1'b1;
            woken_id_nxt    = csq_pkg::ID_PORT_W'(rd_data);
            head_nxt        = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
            total_nxt       = total_r - TOT_W'(1);
          end else if (free_r == '1) begin
            status_nxt = csq_pkg::STAT_SAT;
          end else begin
            free_nxt = free_r + COUNT_WIDTH'(1);
          end
        end
        default: begin
          // query and the unused code leave the state alone
        end
      endcase
    end
    if (free_nxt != '0) begin
      value_nxt = csq_pkg::VALUE_W'(free_nxt);
    end else begin
      value_nxt = csq_pkg::VALUE_W'(0) - csq_pkg::VALUE_W'(total_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else begin
      free_r  <= free_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      tid_r  <= ID_WIDTH'(in_thread_id);
    end
    if (cmd.exec) begin
      status_r      <= status_nxt;
      woken_valid_r <= woken_valid_nxt;
      woken_id_r    <= woken_id_nxt;
      value_r       <= value_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_woken_valid = woken_valid_r;
  assign out_woken_id    = woken_id_r;
  assign out_value       = value_r;

endmodule

// File: design/counting_semaphore_wait_queue_unit.sv
// Counting semaphore with a queue of blocked waiters. Each item is a take, a
// release or a query with a thread id; each gives one result with a status,
// the id of any waiter woken by a release, and the value (the free count when
// above zero, else minus the number of waiters). An item is first
// registered, which starts the read of the oldest waiter from the queue RAM,
// and then executed, which updates the count and queue pointers and loads
// the output register. The next item is taken while the previous result
// leaves, but only once the previous item has executed. Writing
// cfg_initial_count loads the free count and empties the queue; it is taken
// whenever no item is being worked on.
module counting_semaphore_wait_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_thread_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_woken_valid,
  output logic [7:0]        out_woken_id,
  output logic signed [8:0] out_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_initial_count
);

  csq_pkg::csq_cmd_t cmd;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  csq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_thread_id      (in_thread_id),
    .cfg_initial_count (cfg_initial_count),
    .out_status        (out_status),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_value         (out_value)
  );

  // an accepted item is latched, then executed, and then has its result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // a waiting result is never overwritten by a new item
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall && !in_stall))
    else $error("item accepted while result stalled");

  // waking a waiter always reports done
  a_wake_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_woken_valid) |-> (out_status == csq_pkg::STAT_DONE))
    else $error("woken waiter with non-done status");

endmodule

// File: dv/csq_checker.sv
module csq_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_thread_id,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic              out_woken_valid,
  input  logic [7:0]        out_woken_id,
  input  logic signed [8:0] out_value,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_initial_count,
  output int unsigned       pending,
  output int unsigned       mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WAIT_SLOTS = 16;

  typedef struct packed {
    logic [1:0]        status;
    logic              woken_valid;
    logic [7:0]        woken_id;
    logic signed [8:0] value;
  } sem_reply_t;

  // shadow of the semaphore
  logic [7:0] free_units;
  logic [7:0] waiting_ids [WAIT_SLOTS];
  logic [3:0] wait_head;
  logic [3:0] wait_tail;
  int unsigned waiters;

  sem_reply_t owed_replies [$];
  int unsigned err_count = 0;

  assign mismatches = err_count;

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("error at %0t ns: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    err_count++;
  endtask

  function automatic sem_reply_t serve_request(logic [1:0] op, logic [7:0] tid);
    sem_reply_t r;
    r = '0;
    r.status = csq_pkg::STAT_DONE;
    case (op)
      csq_pkg::FUNC_TAKE: begin
        if (free_units != 0) begin
          free_units--;
        end else if (waiters >= WAIT_SLOTS) begin
          r.status = csq_pkg::STAT_FULL;
        end else begin
          waiting_ids[wait_tail] = tid;
          wait_tail++;
          waiters++;
          r.status = csq_pkg::STAT_BLOCKED;
        end
      end
      csq_pkg::FUNC_RELEASE: begin
        if (waiters != 0) begin
          r.woken_valid = 1'b1;
          r.woken_id = waiting_ids[wait_head];
          wait_head++;
          waiters--;
        end else if (free_units == 8'hFF) begin
          r.status = csq_pkg::STAT_SAT;
        end else begin
          free_units++;
        end
      end
      default: begin
        // query, and the spare code behaves as one
      end
    endcase
    if (free_units != 0)
      r.value = {1'b0, free_units};
    else
      r.value = 9'(-int'(waiters));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sem_reply_t got;
    sem_reply_t want;
    if (!rst_n) begin
      free_units = '0;
      wait_head = '0;
      wait_tail = '0;
      waiters = 0;
      owed_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.woken_valid = out_woken_valid;
        got.woken_id = out_woken_id;
        got.value = out_value;
        if (owed_replies.size() == 0) begin
          report("unrequested result, status", '0, 32'(got.status));
        end else begin
          want = owed_replies.pop_front();
          if (got.status !== want.status)
            report("status", 32'(want.status), 32'(got.status));
          if (got.woken_valid !== want.woken_valid)
            report("woken_valid", 32'(want.woken_valid), 32'(got.woken_valid));
          if (got.woken_id !== want.woken_id)
            report("woken_id", 32'(want.woken_id), 32'(got.woken_id));
          if (got.value !== want.value)
            report("value", 32'(want.value), 32'(got.value));
        end
      end
      if (cfg_valid && cfg_ready) begin
        free_units = cfg_initial_count;
        wait_head = '0;
        wait_tail = '0;
        waiters = 0;
      end
      if (in_valid && !in_stall)
        owed_replies.push_back(serve_request(in_func, in_thread_id));
    end
    pending <= owed_replies.size();
  end

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 142;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = csq_pkg::FUNC_QUERY;
  logic [7:0]        in_thread_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic              out_woken_valid;
  logic [7:0]        out_woken_id;
  logic signed [8:0] out_value;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_initial_count = '0;
  int unsigned       pending;
  int unsigned       mismatches;

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  counting_semaphore_wait_queue_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_value         (out_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_initial_count (cfg_initial_count)
  );

  csq_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_woken_valid   (out_woken_valid),
    .out_woken_id      (out_woken_id),
    .out_value         (out_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_initial_count (cfg_initial_count),
    .pending           (pending),
    .mismatches        (mismatches)
  );

  // receiver back-pressure: free flow, light, heavy and a fixed rhythm
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  task automatic send(logic [1:0] op, logic [7:0] tid);
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= op;
    in_thread_id <= tid;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_off(int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    hold_off(1);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_count(logic [7:0] units);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_initial_count <= units;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned burst_left;
    int unsigned take_pct;
    int unsigned pick;
    logic [1:0] op;
    logic [7:0] units;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty semaphore: fill the wait queue past its depth, then wake two
    load_count(8'd0);
    send(csq_pkg::FUNC_QUERY, 8'h00);
    for (int i = 0; i < 17; i++)
      send(csq_pkg::FUNC_TAKE, 8'(i * 17));
    send(csq_pkg::FUNC_RELEASE, 8'h3C);
    send(csq_pkg::FUNC_RELEASE, 8'hC3);
    send(FUNC_SPARE, 8'hA5);

    // full count: release saturates, then take and give back
    load_count(8'hFF);
    send(csq_pkg::FUNC_RELEASE, 8'hFF);
    send(csq_pkg::FUNC_TAKE, 8'h5A);
    send(csq_pkg::FUNC_RELEASE, 8'h00);
    send(csq_pkg::FUNC_QUERY, 8'hFF);

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 6)
        0: units = 8'd0;
        1: units = 8'hFF;
        2: units = 8'd1;
        3: units = 8'hFE;
        4: units = 8'($urandom_range(2, 253));
        default: units = 8'($urandom_range(0, 16));
      endcase
      load_count(units);
      case ($urandom_range(2))
        0: take_pct = 15;
        1: take_pct = 50;
        default: take_pct = 85;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(3) != 0)
            hold_off($urandom_range(1, 6));
          burst_left = $urandom_range(1, 30);
        end
        if ($urandom_range(199) == 0)
          drain();
        pick = $urandom_range(99);
        if (pick < take_pct)
          op = csq_pkg::FUNC_TAKE;
        else if (pick < 94)
          op = csq_pkg::FUNC_RELEASE;
        else if (pick < 98)
          op = csq_pkg::FUNC_QUERY;
        else
          op = FUNC_SPARE;
        send(op, 8'($urandom_range(255)));
        burst_left--;
      end
    end

    drain();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
